>>> hw/rtl/adq_pkg.sv
// shared types and constants for the alarm deadline queue
package adq_pkg;

	localparam int unsigned TIME_W = 48;
	localparam int unsigned DMS_W  = 24;
	localparam int unsigned TAG_W  = 8;
	localparam int unsigned PROD_W = 34;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned PEND_W = 6;

	// expiries per time beat before the rest wait for a later one
	localparam int unsigned MAX_RESULTS = 32;
	localparam int unsigned RES_W = $clog2(MAX_RESULTS);

	localparam logic [9:0]        US_PER_MS = 10'd1000;
	localparam logic [TIME_W-1:0] IDLE_RESET = 48'd10000000000;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic OP_SCHED = 1'b0;
	localparam logic OP_TIME  = 1'b1;

	localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXP  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FULL = 1'b1;

	// configuration port
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 64;
	localparam logic REG_IDLE_WAIT = 1'b0;

	typedef struct packed {
		logic [TIME_W-1:0] dl;
		logic [TAG_W-1:0]  tag;
	} adq_entry_t;

	typedef struct packed {
		logic              ins;
		logic              pop;
		logic [TIME_W-1:0] dl;
		logic [TAG_W-1:0]  tag;
	} adq_cmd_t;

	// view of the two earliest entries
	typedef struct packed {
		logic [TIME_W-1:0] dl0;
		logic [TAG_W-1:0]  tag0;
		logic [TIME_W-1:0] dl1;
	} adq_head_t;

endpackage

>>> hw/rtl/adq_in_if.sv
// request channel: schedule and time beats
interface adq_in_if
	import adq_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              op;
	logic [DMS_W-1:0]  delay_ms;
	logic [TAG_W-1:0]  alarm_tag;
	logic [TIME_W-1:0] now_us;

	modport source (output valid, op, delay_ms, alarm_tag, now_us, input ready);
	modport sink (input valid, op, delay_ms, alarm_tag, now_us, output ready);
endinterface

>>> hw/rtl/adq_out_if.sv
// result channel: acknowledges and expiries
interface adq_out_if
	import adq_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic              status;
	logic [TAG_W-1:0]  expired_tag;
	logic [TIME_W-1:0] wait_us;
	logic [PEND_W-1:0] pending;
	logic              last;

	modport source (output valid, kind, status, expired_tag, wait_us, pending, last,
		input ready);
	modport sink (input valid, kind, status, expired_tag, wait_us, pending, last,
		output ready);
endinterface

>>> hw/rtl/adq_cell.sv
// one slot of the sorted alarm row
module adq_cell
	import adq_pkg::*;
(
	input  logic       clk,
	input  adq_cmd_t   cmd,
	input  logic       occ,
	input  logic       at_end,
	input  adq_entry_t left_ent,
	input  logic       left_gt,
	input  adq_entry_t right_ent,
	output adq_entry_t ent,
	output logic       gt
);

	adq_entry_t ent_q;

	// later than the incoming deadline, so it moves one place right
	assign gt  = occ && (ent_q.dl > cmd.dl);
	assign ent = ent_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left_gt) begin
				ent_q <= left_ent;
			end else if (gt || at_end) begin
				ent_q <= '{dl: cmd.dl, tag: cmd.tag};
			end
		end else if (cmd.pop) begin
			ent_q <= right_ent;
		end
	end

endmodule

>>> hw/rtl/adq_chain.sv
// row of alarm cells with the fill count
module adq_chain
	import adq_pkg::*;
#(
	parameter int unsigned N = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  adq_cmd_t                   cmd,
	output logic [$clog2(N+1)-1:0]     cnt,
	output adq_head_t                  head
);

	localparam int unsigned CW = $clog2(N+1);
	localparam int unsigned SECOND = (N > 1) ? 1 : 0;

	logic [CW-1:0] cnt_q;
	adq_entry_t    ent [N];
	logic          gt  [N+1];

	assign gt[0] = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		adq_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.occ       (CW'(i) < cnt_q),
			.at_end    (CW'(i) == cnt_q),
			.left_ent  (ent[(i > 0) ? i - 1 : 0]),
			.left_gt   (gt[i]),
			.right_ent (ent[(i < N - 1) ? i + 1 : i]),
			.ent       (ent[i]),
			.gt        (gt[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.ins) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.pop) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	assign cnt       = cnt_q;
	assign head.dl0  = ent[0].dl;
	assign head.tag0 = ent[0].tag;
	assign head.dl1  = ent[SECOND].dl;

endmodule

>>> hw/rtl/alarm_deadline_queue_top.sv
// top level of the alarm deadline queue
//
//  channel  dir  handshake         payload
//  req      in   valid/ready       op, delay_ms, alarm_tag, now_us
//  rsp      out  valid/ready       kind, status, expired_tag, wait_us, pending, last
//  apb      in   psel/penable      idle_wait_us at byte address 0 (64 bit)
//
// a schedule beat steps through accept (delay times 1000), deadline add,
// insert into the cell row and acknowledge into the output register; a
// refused alarm skips the insert
// a time beat gives one expiry per cycle while the output register is free,
// popped from the head cell of the row
// reset clears the fill count, the current time and all control state;
// the cell contents are left as they are
// a full output register holds the sequencer until the result beat is taken,
// and req is only ready while the sequencer is idle
module alarm_deadline_queue_top
	import adq_pkg::*;
#(
	parameter int unsigned MAX_ALARMS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	adq_in_if.sink             req,
	adq_out_if.source          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int unsigned CW = $clog2(MAX_ALARMS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_INS,
		S_ACK,
		S_EXP
	} state_t;

	state_t             state_q;
	logic [TIME_W-1:0]  cur_q;     // current time
	logic [TIME_W-1:0]  idle_q;    // wait reported on an empty queue
	logic [PROD_W-1:0]  prod_q;    // delay in microseconds
	logic [TIME_W-1:0]  dl_q;      // deadline of the alarm being scheduled
	logic [TAG_W-1:0]   tag_q;
	logic               full_q;
	logic [RES_W-1:0]   n_q;       // expiries so far in this time beat

	logic               ov_q;
	logic [KIND_W-1:0]  kind_q;
	logic               status_q;
	logic [TAG_W-1:0]   etag_q;
	logic [TIME_W-1:0]  wait_q;
	logic [PEND_W-1:0]  pend_q;
	logic               last_q;

	adq_cmd_t           cmd;
	adq_head_t          head;
	logic [CW-1:0]      cnt;

	logic               out_free;
	logic               rsp_load;  // a result beat enters the output register
	logic               due0;
	logic               due1;
	logic               fin;
	logic [TIME_W:0]    dl_sum;
	logic [TIME_W-1:0]  wait_now;  // wait measured against the head cell
	logic [TIME_W-1:0]  wait_pop;  // wait once the head cell has left

	// ---------------------------------------------------------------
	// cell row
	// ---------------------------------------------------------------
	adq_chain #(
		.N (MAX_ALARMS)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cnt    (cnt),
		.head   (head)
	);

	assign out_free = !ov_q || rsp.ready;
	assign rsp_load = out_free && ((state_q == S_ACK) || (state_q == S_EXP));

	// head and second entry against the current time
	assign due0 = (cnt != '0) && (head.dl0 <= cur_q);
	assign due1 = head.dl1 <= cur_q;

	// stop after this expiry: result limit, queue drained, or next one not due
	assign fin = (n_q == RES_W'(MAX_RESULTS - 1)) || (cnt == CW'(1)) || !due1;

	always_comb begin
		if (cnt == '0) begin
			wait_now = idle_q;
		end else if (head.dl0 <= cur_q) begin
			wait_now = '0;
		end else begin
			wait_now = head.dl0 - cur_q;
		end
	end

	always_comb begin
		if (cnt == CW'(1)) begin
			wait_pop = idle_q;
		end else if (due1) begin
			wait_pop = '0;
		end else begin
			wait_pop = head.dl1 - cur_q;
		end
	end

	// saturating deadline add
	assign dl_sum = {1'b0, cur_q} + (TIME_W+1)'(prod_q);

	always_comb begin
		cmd.ins = (state_q == S_INS);
		cmd.pop = (state_q == S_EXP) && out_free && due0;
		cmd.dl  = dl_q;
		cmd.tag = tag_q;
	end

	assign req.ready = (state_q == S_IDLE);

	// ---------------------------------------------------------------
	// sequencer and output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cur_q    <= '0;
			prod_q   <= '0;
			dl_q     <= '0;
			tag_q    <= '0;
			full_q   <= 1'b0;
			n_q      <= '0;
			ov_q     <= 1'b0;
			kind_q   <= KIND_ACK;
			status_q <= ST_OK;
			etag_q   <= '0;
			wait_q   <= '0;
			pend_q   <= '0;
			last_q   <= 1'b0;
		end else begin
			if (rsp_load) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						prod_q <= PROD_W'(req.delay_ms) * PROD_W'(US_PER_MS);
						tag_q  <= req.alarm_tag;
						n_q    <= '0;
						if (req.op == OP_TIME) begin
							cur_q   <= req.now_us;
							state_q <= S_EXP;
						end else begin
							state_q <= S_ADD;
						end
					end
				end
				S_ADD: begin
					dl_q   <= dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];
					full_q <= (cnt >= CW'(MAX_ALARMS));
					// a refused alarm leaves the row untouched
					state_q <= (cnt >= CW'(MAX_ALARMS)) ? S_ACK : S_INS;
				end
				S_INS: begin
					state_q <= S_ACK;
				end
				S_ACK: begin
					if (out_free) begin
						kind_q   <= KIND_ACK;
						status_q <= full_q ? ST_FULL : ST_OK;
						etag_q   <= '0;
						wait_q   <= wait_now;
						pend_q   <= PEND_W'(cnt);
						last_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_EXP: begin
					if (out_free) begin
						status_q <= ST_OK;
						if (due0) begin
							kind_q  <= KIND_EXP;
							etag_q  <= head.tag0;
							wait_q  <= fin ? wait_pop : '0;
							pend_q  <= PEND_W'(cnt - CW'(1));
							last_q  <= fin;
							n_q     <= n_q + RES_W'(1);
							if (fin) begin
								state_q <= S_IDLE;
							end
						end else begin
							// nothing due on this time beat
							kind_q  <= KIND_NONE;
							etag_q  <= '0;
							wait_q  <= wait_now;
							pend_q  <= PEND_W'(cnt);
							last_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.kind        = kind_q;
	assign rsp.status      = status_q;
	assign rsp.expired_tag = etag_q;
	assign rsp.wait_us     = wait_q;
	assign rsp.pending     = pend_q;
	assign rsp.last        = last_q;

	// ---------------------------------------------------------------
	// configuration port
	// ---------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= IDLE_RESET;
		end else if (psel && penable && pwrite && (paddr[3] == REG_IDLE_WAIT)) begin
			idle_q <= pwdata[TIME_W-1:0];
		end
	end

	assign prdata = (paddr[3] == REG_IDLE_WAIT) ? PDATA_W'(idle_q) : '0;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt <= CW'(MAX_ALARMS))
		else $error("fill count beyond capacity");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> cnt == $past(cnt) + CW'(1))
		else $error("insert did not grow the row");

	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt >= CW'(2)) && (state_q == S_EXP) |-> head.dl0 <= head.dl1)
		else $error("row head out of deadline order");

	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && (kind_q == KIND_NONE) |-> last_q)
		else $error("empty expiry result not marked last");

endmodule

>>> tb/adq_tb_pkg.sv
`timescale 1ns / 100ps
// shadow of the alarm queue that predicts and checks result beats
package adq_tb_pkg;
	import adq_pkg::*;

	localparam int unsigned CAPACITY = 32;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              status;
		logic [TAG_W-1:0]  tag;
		logic [TIME_W-1:0] wait_us;
		logic [PEND_W-1:0] pending;
		logic              last;
	} rsp_beat_t;

	class alarm_queue_shadow;
		adq_entry_t        alarms[$];
		rsp_beat_t         owed_beats[$];
		logic [TIME_W-1:0] clock_us;
		logic [TIME_W-1:0] idle_wait;
		int                errors;

		function new();
			clock_us  = '0;
			idle_wait = IDLE_RESET;
			errors    = 0;
		endfunction

		function void write_reg(int unsigned index, logic [PDATA_W-1:0] value);
			if (index == REG_IDLE_WAIT) begin
				idle_wait = value[TIME_W-1:0];
			end
		endfunction

		function logic [TIME_W-1:0] next_wait();
			if (alarms.size() == 0) begin
				return idle_wait;
			end
			if (alarms[0].dl <= clock_us) begin
				return '0;
			end
			return alarms[0].dl - clock_us;
		endfunction

		function void add_beat(logic [KIND_W-1:0] kind, logic status, logic [TAG_W-1:0] tag,
			logic [TIME_W-1:0] wait_us, logic last);
			rsp_beat_t b;
			b.kind    = kind;
			b.status  = status;
			b.tag     = tag;
			b.wait_us = wait_us;
			b.pending = PEND_W'(alarms.size());
			b.last    = last;
			owed_beats.push_back(b);
		endfunction

		function void note_request(logic op, logic [DMS_W-1:0] delay_ms,
			logic [TAG_W-1:0] tag, logic [TIME_W-1:0] now_us);
			logic [TIME_W:0] sum;
			adq_entry_t      e;
			int              pos;
			int              n;
			logic            fin;
			if (op == OP_SCHED) begin
				if (alarms.size() >= CAPACITY) begin
					add_beat(KIND_ACK, ST_FULL, '0, next_wait(), 1'b1);
					return;
				end
				sum   = {1'b0, clock_us} +
					(TIME_W+1)'(delay_ms) * (TIME_W+1)'(US_PER_MS);
				e.dl  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
				e.tag = tag;
				// equal deadlines keep scheduling order
				pos = alarms.size();
				while (pos > 0 && alarms[pos-1].dl > e.dl) begin
					pos--;
				end
				alarms.insert(pos, e);
				add_beat(KIND_ACK, ST_OK, '0, next_wait(), 1'b1);
			end else begin
				clock_us = now_us;
				n = 0;
				while (n < MAX_RESULTS && alarms.size() > 0 && alarms[0].dl <= clock_us) begin
					e   = alarms.pop_front();
					fin = (n + 1 == MAX_RESULTS) || alarms.size() == 0 ||
						alarms[0].dl > clock_us;
					add_beat(KIND_EXP, ST_OK, e.tag, fin ? next_wait() : '0, fin);
					n++;
				end
				if (n == 0) begin
					add_beat(KIND_NONE, ST_OK, '0, next_wait(), 1'b1);
				end
			end
		endfunction

		function void compare(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(rsp_beat_t got);
			rsp_beat_t want;
			if (owed_beats.size() == 0) begin
				$error("result beat with nothing expected: kind %0d tag %0d", got.kind, got.tag);
				errors++;
				return;
			end
			want = owed_beats.pop_front();
			compare("kind", TIME_W'(want.kind), TIME_W'(got.kind));
			compare("status", TIME_W'(want.status), TIME_W'(got.status));
			compare("expired_tag", TIME_W'(want.tag), TIME_W'(got.tag));
			compare("wait_us", want.wait_us, got.wait_us);
			compare("pending", TIME_W'(want.pending), TIME_W'(got.pending));
			compare("last", TIME_W'(want.last), TIME_W'(got.last));
		endfunction
	endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// testbench top: drives schedule and time beats, checks every result beat against the shadow
module tb_top;
	import adq_pkg::*;
	import adq_tb_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 9;
	localparam int PHASE_ITEMS   = 50;
	// margin well past any schedule beat still in flight
	localparam int SETTLE_CYCLES = 16;

	localparam logic [PADDR_W-1:0] IDLE_WAIT_ADDR = PADDR_W'(8 * REG_IDLE_WAIT);
	// register index 1: nothing lives there, writes must be dropped
	localparam logic [PADDR_W-1:0] SPARE_ADDR     = PADDR_W'(8);

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	adq_in_if  req ();
	adq_out_if rsp ();

	alarm_deadline_queue_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	alarm_queue_shadow shadow;

	int        sent;        // request beats accepted so far
	int        burst_left;  // beats left in the current sender burst
	int        ready_hold = 0;
	int        ready_pick;
	logic      ready_level = 1'b0;
	logic      sink_ready = 1'b0;
	rsp_beat_t beat_seen;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// receiver stall pattern: runs of ready, short and long stalls, and
	// now and then a long stretch with no stall at all
	assign rsp.ready = sink_ready;

	always @(posedge clk) begin
		if (ready_hold == 0) begin
			ready_pick = $urandom_range(0, 9);
			if (ready_pick < 5) begin
				ready_level = 1'b1;
				ready_hold  = $urandom_range(1, 16);
			end else if (ready_pick < 8) begin
				ready_level = 1'b0;
				ready_hold  = $urandom_range(1, 4);
			end else if (ready_pick == 8) begin
				ready_level = 1'b0;
				ready_hold  = $urandom_range(5, 12);
			end else begin
				ready_level = 1'b1;
				ready_hold  = $urandom_range(30, 60);
			end
		end
		ready_hold--;
		sink_ready <= ready_level;
	end

	// result monitor: every beat taken is checked against the oldest one owed
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			beat_seen = {rsp.kind, rsp.status, rsp.expired_tag, rsp.wait_us, rsp.pending,
				rsp.last};
			shadow.check_result(beat_seen);
		end
	end

	function automatic logic [TIME_W-1:0] rand_time();
		return TIME_W'({$urandom(), $urandom()});
	endfunction

	// one request beat; the sender works in bursts with random gaps between them
	task automatic send(logic op, logic [DMS_W-1:0] delay_ms, logic [TAG_W-1:0] tag,
		logic [TIME_W-1:0] now_us);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) :
				$urandom_range(1, 10);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid     <= 1'b1;
		req.op        <= op;
		req.delay_ms  <= delay_ms;
		req.alarm_tag <= tag;
		req.now_us    <= now_us;
		do @(posedge clk); while (req.ready !== 1'b1);
		shadow.note_request(op, delay_ms, tag, now_us);
		sent++;
	endtask

	// unused fields carry junk so the block is seen to ignore them
	task automatic schedule(logic [DMS_W-1:0] delay_ms, logic [TAG_W-1:0] tag);
		send(OP_SCHED, delay_ms, tag, rand_time());
	endtask

	task automatic tick(logic [TIME_W-1:0] now_us);
		send(OP_TIME, DMS_W'($urandom), TAG_W'($urandom), now_us);
	endtask

	// sender holds off until every owed result beat has been taken
	task automatic drain();
		req.valid <= 1'b0;
		while (shadow.owed_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write: setup cycle, then access cycle until pready, then back to idle
	task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		shadow.write_reg(addr / 8, value);
		@(posedge clk);
	endtask

	task automatic run_directed();
		tick('0);                             // empty queue reports the idle wait
		schedule('0, 8'h00);                  // zero delay, due at once
		tick('0);                             // deadline equal to now expires
		schedule({DMS_W{1'b1}}, 8'hff);       // longest delay
		schedule(DMS_W'(3), 8'h01);           // three equal deadlines
		schedule(DMS_W'(3), 8'h02);
		schedule(DMS_W'(3), 8'h03);
		schedule(DMS_W'(1), 8'ha5);
		tick(TIME_W'(2999));                  // one due, one microsecond short of the next
		tick(TIME_W'(3000));                  // ties leave in scheduling order
		tick(TIME_W'(500));                   // time goes backwards
		schedule(DMS_W'(2), 8'h5a);
		tick(48'hffff_ffff_f000);             // everything left expires
		schedule({DMS_W{1'b1}}, 8'h3c);       // deadline overflows and saturates
		schedule('0, 8'hc3);
		tick(TIME_MAX - 1);
		tick(TIME_MAX);                       // the saturated alarm goes last
		tick('0);
	endtask

	// fill the store, knock on it while full, then empty it with time beats, the last at the top of time
	task automatic run_fill();
		while (shadow.alarms.size() < CAPACITY) begin
			schedule(DMS_W'($urandom_range(0, 2000)), TAG_W'($urandom));
		end
		repeat ($urandom_range(1, 3)) schedule(DMS_W'($urandom), TAG_W'($urandom));
		tick(shadow.clock_us + TIME_W'($urandom_range(0, 1000000)));
		tick(TIME_MAX);
		tick(TIME_W'($urandom_range(0, 100000)));
	endtask

	// well-formed traffic: short delays and small time steps so alarms tie and expire
	task automatic run_mixed();
		int n;
		n = $urandom_range(3, 12);
		repeat (n) begin
			if ($urandom_range(0, 9) < 6) begin
				schedule(DMS_W'($urandom_range(0, 40)), TAG_W'($urandom));
			end else begin
				tick(shadow.clock_us + TIME_W'($urandom_range(0, 30000)));
			end
		end
	endtask

	// full-range junk, sometimes followed by a flush back to early time
	task automatic run_noise();
		repeat ($urandom_range(1, 4)) begin
			send(1'($urandom_range(0, 1)), DMS_W'($urandom), TAG_W'($urandom), rand_time());
		end
		if ($urandom_range(0, 1) == 1) begin
			tick(TIME_MAX);
			tick(TIME_W'($urandom_range(0, 50000)));
		end
	endtask

	// near the top of time, where some deadlines saturate
	task automatic run_top_of_time();
		tick(TIME_MAX - TIME_W'($urandom_range(0, 20000)));
		repeat ($urandom_range(1, 6)) schedule(DMS_W'($urandom_range(0, 40)), TAG_W'($urandom));
		tick(TIME_MAX - TIME_W'($urandom_range(0, 10000)));
		tick(TIME_MAX);
		tick(TIME_W'($urandom_range(0, 50000)));
	endtask

	task automatic run_phase(int target);
		int pick;
		while (sent < target) begin
			pick = $urandom_range(0, 19);
			if (pick < 13) begin
				run_mixed();
			end else if (pick == 13) begin
				run_fill();
			end else if (pick < 16) begin
				run_noise();
			end else if (pick < 18) begin
				run_top_of_time();
			end else begin
				drain();
			end
		end
		drain();
	endtask

	initial begin
		shadow = new();
		sent = 0;
		burst_left = 0;
		req.valid     <= 1'b0;
		req.op        <= OP_SCHED;
		req.delay_ms  <= '0;
		req.alarm_tag <= '0;
		req.now_us    <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		arst_n  <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part runs on the reset idle value
		run_directed();
		drain();

		// idle wait at its floor
		write_reg(IDLE_WAIT_ADDR, '0);
		run_fill();
		drain();
		run_phase(sent + PHASE_ITEMS);

		// idle wait at its ceiling
		write_reg(IDLE_WAIT_ADDR, PDATA_W'(TIME_MAX));
		run_phase(sent + PHASE_ITEMS);

		// a write to an empty index, then a random value with the top bits set
		write_reg(SPARE_ADDR, {$urandom(), $urandom()});
		write_reg(IDLE_WAIT_ADDR, {$urandom(), $urandom()} | {16'hffff, 48'h0});
		run_phase(sent + PHASE_ITEMS);

		// back to the reset value
		write_reg(IDLE_WAIT_ADDR, PDATA_W'(IDLE_RESET));
		run_mixed();
		run_noise();
		drain();

		if (shadow.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#20000000;
		$display("FAILURE");
		$finish;
	end

endmodule
